FILE: rtl/core/c8x_pkg.sv
// Package with shared types, codes and constants of the CHIP-8 instruction executor.
`default_nettype none
package c8x_pkg;
    localparam int STACK_DEPTH_DEF = 16;
    localparam logic [15:0] START_PC_RESET = 16'h0200;

    localparam logic [1:0] REQ_INSTR = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_COLL  = 2'd2;

    localparam logic [2:0] KIND_DONE  = 3'd0;
    localparam logic [2:0] KIND_WRITE = 3'd1;
    localparam logic [2:0] KIND_READ  = 3'd2;
    localparam logic [2:0] KIND_CLS   = 3'd3;
    localparam logic [2:0] KIND_DRAW  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNKNOWN   = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_UNIMPL    = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // latch the input word
        logic execute;  // execute the latched word
        logic emit;     // present the current result word
        logic advance;  // result word taken, step the burst
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic burst_last;
    } stat_t;

    // Decimal digits of a byte, by compare and subtract.
    function automatic logic [11:0] bcd_of(input logic [7:0] v);
        logic [3:0] h;
        logic [3:0] t;
        logic [3:0] o;
        h = 4'd0;
        t = 4'd0;
        o = 4'd0;
        if (v >= 8'd200) h = 4'd2;
        else if (v >= 8'd100) h = 4'd1;
        o = 4'(v - 8'(h) * 8'd100);
        t = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if ((v - 8'(h) * 8'd100) >= 8'(k * 10)) t = 4'(k);
        end
        o = 4'((v - 8'(h) * 8'd100) - 8'(t) * 8'd10);
        return {h, t, o};
    endfunction
endpackage
`default_nettype wire

FILE: rtl/core/chip8_instruction_executor.sv
// Top level of the CHIP-8 instruction executor.
// The input channel (in_valid/in_ready) moves one word: a fetched
// instruction, a returned memory byte for a pending Fx65 load, or the draw
// collision flag. The output channel (out_valid/out_ready) moves result
// words: done, memory write, memory read, clear screen or draw. Every
// result of one input carries the same status and next_pc; the final one
// has last set. Fx33 gives three writes, Fx55 and Fx65 give x+1 words.
// An input is latched on acceptance, executed in the execute state, and
// its results are then shown one by one in the emit state.
// The block holds one word at a time; in_ready is high only when idle.
// When the receiver stalls, the shown result holds until it is taken.
// Reset clears the architectural and result registers, the stack pointer
// and pending loads, and sets the program counter to 0x200; the latched
// input word has no reset. A start_pc write loads the program counter at
// once. The return stack is a small RAM with no reset; entries are only
// read after they have been pushed.
`default_nettype none
module chip8_instruction_executor #(
    parameter int STACK_DEPTH = c8x_pkg::STACK_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [15:0] instruction,
    input  wire logic [7:0]  read_data,
    input  wire logic        collision,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [2:0]  kind,
    output logic      [2:0]  status,
    output logic      [15:0] mem_addr,
    output logic      [7:0]  mem_data,
    output logic      [7:0]  draw_x,
    output logic      [7:0]  draw_y,
    output logic      [3:0]  draw_rows,
    output logic      [15:0] next_pc,
    output logic             last
);
    c8x_pkg::cmd_t  cmd;
    c8x_pkg::stat_t st;

    // The controller sequences latch, execute and the result burst.
    c8x_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    // The datapath holds all architectural state and forms each result.
    c8x_dpath #(.STACK_DEPTH(STACK_DEPTH)) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .req_type    (req_type),
        .instruction (instruction),
        .read_data   (read_data),
        .collision   (collision),
        .kind        (kind),
        .status      (status),
        .mem_addr    (mem_addr),
        .mem_data    (mem_data),
        .draw_x      (draw_x),
        .draw_y      (draw_y),
        .draw_rows   (draw_rows),
        .next_pc     (next_pc),
        .last        (last)
    );
endmodule
`default_nettype wire

FILE: rtl/core/c8x_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module c8x_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/c8x_ctrl.sv
// Controller state machine of the CHIP-8 instruction executor.
`default_nettype none
module c8x_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire c8x_pkg::stat_t st,
    output c8x_pkg::cmd_t      cmd
);
    c8x_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= c8x_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd         = '0;
        case (state_reg)
            c8x_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = c8x_pkg::S_EXEC;
                end
            end
            c8x_pkg::S_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = c8x_pkg::S_EMIT;
            end
            c8x_pkg::S_EMIT:
            begin
                out_valid = 1'b1;
                cmd.emit  = 1'b1;
                if (out_ready)
                begin
                    // The counter stays on the final word once it is taken.
                    if (st.burst_last)
                    begin
                        state_next = c8x_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = c8x_pkg::S_IDLE;
            end
        endcase
    end

    // A word is taken only while no result is shown.
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("input taken while a result is pending");
    // Acceptance always leads to execution next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == c8x_pkg::S_EXEC))
        else $error("accept not followed by execute");
    // The final result returns the controller to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && st.burst_last) |=> in_ready)
        else $error("burst end not followed by idle");
endmodule
`default_nettype wire

FILE: rtl/core/c8x_dpath.sv
// Datapath of the CHIP-8 instruction executor: registers, stack, decode and results.
`default_nettype none
module c8x_dpath #(
    parameter int STACK_DEPTH = c8x_pkg::STACK_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire c8x_pkg::cmd_t cmd,
    output c8x_pkg::stat_t     st,
    input  wire logic          cfg_we,
    input  wire logic [15:0]   cfg_wdata,
    input  wire logic [1:0]    req_type,
    input  wire logic [15:0]   instruction,
    input  wire logic [7:0]    read_data,
    input  wire logic          collision,
    output logic      [2:0]    kind,
    output logic      [2:0]    status,
    output logic      [15:0]   mem_addr,
    output logic      [7:0]    mem_data,
    output logic      [7:0]    draw_x,
    output logic      [7:0]    draw_y,
    output logic      [3:0]    draw_rows,
    output logic      [15:0]   next_pc,
    output logic               last
);
    localparam int AW = $clog2(STACK_DEPTH > 1 ? STACK_DEPTH : 2);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    logic [7:0]     v_reg [16];
    logic [15:0]    i_reg;
    logic [15:0]    pc_reg;
    logic [SPW-1:0] sp_reg;
    logic [7:0]     dt_reg;
    logic [4:0]     pend_reg;
    logic [3:0]     slot_reg;

    logic [1:0]  type_reg;
    logic [15:0] w_reg;
    logic [7:0]  rd_reg;
    logic        col_reg;

    // Result burst.
    logic [2:0]  kind_reg;
    logic [2:0]  status_reg;
    logic [3:0]  cnt_reg;
    logic [3:0]  top_reg;
    logic [11:0] bcd_reg;

    logic        stk_we;
    logic [AW-1:0] stk_addr;
    logic [15:0] stk_rdata;

    logic [3:0] x;
    logic [3:0] y;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] kk;
    logic [15:0] pc2;
    logic [8:0] sum;
    logic is_call;

    assign x   = w_reg[11:8];
    assign y   = w_reg[7:4];
    assign kk  = w_reg[7:0];
    assign a   = v_reg[x];
    assign b   = v_reg[y];
    assign pc2 = pc_reg + 16'd2;
    assign sum = {1'b0, a} + {1'b0, b};
    assign is_call = (w_reg[15:12] == 4'h2) && ({{(32-SPW){1'b0}}, sp_reg} < STACK_DEPTH);

    // The stack read address is set when the word is latched, so the top
    // entry is ready when the word executes.
    always_comb
    begin
        stk_we   = cmd.execute && (type_reg == c8x_pkg::REQ_INSTR) && is_call;
        if (cmd.execute)
        begin
            stk_addr = sp_reg[AW-1:0];
        end
        else
        begin
            stk_addr = AW'(sp_reg - SPW'(1));
        end
    end

    c8x_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .addr  (stk_addr),
        .wdata (pc2),
        .rdata (stk_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            type_reg <= req_type;
            w_reg    <= instruction;
            rd_reg   <= read_data;
            col_reg  <= collision;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 16; k++) v_reg[k] <= 8'd0;
            i_reg      <= 16'd0;
            pc_reg     <= c8x_pkg::START_PC_RESET;
            sp_reg     <= '0;
            dt_reg     <= 8'd0;
            pend_reg   <= 5'd0;
            slot_reg   <= 4'd0;
            kind_reg   <= c8x_pkg::KIND_DONE;
            status_reg <= c8x_pkg::ST_OK;
            cnt_reg    <= 4'd0;
            top_reg    <= 4'd0;
            bcd_reg    <= 12'd0;
        end
        else if (cfg_we)
        begin
            pc_reg <= cfg_wdata;
        end
        else if (cmd.execute)
        begin
            kind_reg   <= c8x_pkg::KIND_DONE;
            status_reg <= c8x_pkg::ST_OK;
            cnt_reg    <= 4'd0;
            top_reg    <= 4'd0;
            case (type_reg)
                c8x_pkg::REQ_BYTE:
                begin
                    if (pend_reg != 5'd0)
                    begin
                        v_reg[slot_reg] <= rd_reg;
                        slot_reg <= slot_reg + 4'd1;
                        pend_reg <= pend_reg - 5'd1;
                    end
                end
                c8x_pkg::REQ_COLL:
                begin
                    v_reg[15] <= {7'd0, col_reg};
                end
                c8x_pkg::REQ_INSTR:
                begin
                    pc_reg <= pc2;
                    case (w_reg[15:12])
                        4'h0:
                        begin
                            if (w_reg == 16'h00E0)
                            begin
                                kind_reg <= c8x_pkg::KIND_CLS;
                            end
                            else if (w_reg == 16'h00EE)
                            begin
                                if (sp_reg == '0)
                                begin
                                    status_reg <= c8x_pkg::ST_UNDERFLOW;
                                end
                                else
                                begin
                                    sp_reg <= sp_reg - SPW'(1);
                                    pc_reg <= stk_rdata;
                                end
                            end
                            else
                            begin
                                pc_reg <= {4'd0, w_reg[11:0]};
                            end
                        end
                        4'h1: pc_reg <= {4'd0, w_reg[11:0]};
                        4'h2:
                        begin
                            if (is_call)
                            begin
                                sp_reg <= sp_reg + SPW'(1);
                                pc_reg <= {4'd0, w_reg[11:0]};
                            end
                            else
                            begin
                                status_reg <= c8x_pkg::ST_OVERFLOW;
                            end
                        end
                        4'h3: if (a == kk) pc_reg <= pc2 + 16'd2;
                        4'h4: if (a != kk) pc_reg <= pc2 + 16'd2;
                        4'h5: if (a == b) pc_reg <= pc2 + 16'd2;
                        4'h6: v_reg[x] <= kk;
                        4'h7: v_reg[x] <= a + kk;
                        4'h8:
                        begin
                            case (w_reg[3:0])
                                4'h0: v_reg[x] <= b;
                                4'h1: v_reg[x] <= a | b;
                                4'h2: v_reg[x] <= a & b;
                                4'h3: v_reg[x] <= a ^ b;
                                4'h4:
                                begin
                                    v_reg[x]  <= sum[7:0];
                                    v_reg[15] <= {7'd0, sum[8]};
                                end
                                4'h5:
                                begin
                                    v_reg[x]  <= a - b;
                                    v_reg[15] <= {7'd0, a >= b};
                                end
                                4'h6:
                                begin
                                    v_reg[x]  <= {1'b0, a[7:1]};
                                    v_reg[15] <= {7'd0, a[0]};
                                end
                                4'h7:
                                begin
                                    v_reg[x]  <= b - a;
                                    v_reg[15] <= {7'd0, b >= a};
                                end
                                4'hE:
                                begin
                                    v_reg[x]  <= {a[6:0], 1'b0};
                                    v_reg[15] <= {7'd0, a[7]};
                                end
                                default: status_reg <= c8x_pkg::ST_UNKNOWN;
                            endcase
                        end
                        4'h9: if (a != b) pc_reg <= pc2 + 16'd2;
                        4'hA: i_reg <= {4'd0, w_reg[11:0]};
                        4'hB, 4'hC: status_reg <= c8x_pkg::ST_UNIMPL;
                        4'hD: kind_reg <= c8x_pkg::KIND_DRAW;
                        4'hE:
                        begin
                            if (kk == 8'h9E || kk == 8'hA1) status_reg <= c8x_pkg::ST_UNIMPL;
                            else status_reg <= c8x_pkg::ST_UNKNOWN;
                        end
                        default:
                        begin
                            case (kk)
                                8'h07: v_reg[x] <= dt_reg;
                                8'h15: dt_reg <= a;
                                8'h1E: i_reg <= i_reg + {8'd0, a};
                                8'h0A, 8'h29, 8'h18: status_reg <= c8x_pkg::ST_UNIMPL;
                                8'h33:
                                begin
                                    kind_reg <= c8x_pkg::KIND_WRITE;
                                    top_reg  <= 4'd2;
                                    bcd_reg  <= c8x_pkg::bcd_of(a);
                                end
                                8'h55:
                                begin
                                    kind_reg <= c8x_pkg::KIND_WRITE;
                                    top_reg  <= x;
                                end
                                8'h65:
                                begin
                                    kind_reg <= c8x_pkg::KIND_READ;
                                    top_reg  <= x;
                                    pend_reg <= {1'b0, x} + 5'd1;
                                    slot_reg <= 4'd0;
                                end
                                default: status_reg <= c8x_pkg::ST_UNKNOWN;
                            endcase
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.advance)
        begin
            cnt_reg <= cnt_reg + 4'd1;
        end
    end

    assign st.burst_last = (cnt_reg == top_reg);

    always_comb
    begin
        kind      = kind_reg;
        status    = status_reg;
        next_pc   = pc_reg;
        last      = (cnt_reg == top_reg);
        mem_addr  = 16'd0;
        mem_data  = 8'd0;
        draw_x    = 8'd0;
        draw_y    = 8'd0;
        draw_rows = 4'd0;
        case (kind_reg)
            c8x_pkg::KIND_WRITE:
            begin
                mem_addr = i_reg + {12'd0, cnt_reg};
                if (kk == 8'h33)
                begin
                    case (cnt_reg[1:0])
                        2'd0:    mem_data = {4'd0, bcd_reg[11:8]};
                        2'd1:    mem_data = {4'd0, bcd_reg[7:4]};
                        default: mem_data = {4'd0, bcd_reg[3:0]};
                    endcase
                end
                else
                begin
                    mem_data = v_reg[cnt_reg];
                end
            end
            c8x_pkg::KIND_READ: mem_addr = i_reg + {12'd0, cnt_reg};
            c8x_pkg::KIND_DRAW:
            begin
                mem_addr  = i_reg;
                draw_x    = a;
                draw_y    = b;
                draw_rows = w_reg[3:0];
            end
            default:
            begin
            end
        endcase
    end

    // The burst counter never runs past the final result.
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= top_reg)
        else $error("burst counter past end");
    // The stack pointer never exceeds the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        {{(32-SPW){1'b0}}, sp_reg} <= STACK_DEPTH)
        else $error("stack pointer out of range");
    // Pending loads never exceed sixteen.
    assert property (@(posedge clk) disable iff (!rst_n) pend_reg <= 5'd16)
        else $error("pending load count out of range");
endmodule
`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for the CHIP-8 instruction executor.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    localparam int STACK_DEPTH = c8x_pkg::STACK_DEPTH_DEF;
    // Request type with no meaning; the block answers it with a plain done word.
    localparam logic [1:0] REQ_SPARE = 2'd3;

    // One result word as seen on the output channel.
    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  status;
        logic [15:0] mem_addr;
        logic [7:0]  mem_data;
        logic [7:0]  draw_x;
        logic [7:0]  draw_y;
        logic [3:0]  draw_rows;
        logic [15:0] next_pc;
        logic        last;
    } result_t;

    // One row of the directed table. Where has_exp is set, the single
    // result word is typed in and is compared against the prediction too.
    typedef struct {
        logic [1:0]  rtype;
        logic [15:0] word;
        logic [7:0]  byte_in;
        logic        coll;
        logic        has_exp;
        logic [2:0]  exp_kind;
        logic [2:0]  exp_status;
        logic [15:0] exp_pc;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [15:0] instruction;
    logic [7:0]  read_data;
    logic        collision;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  kind;
    logic [2:0]  status;
    logic [15:0] mem_addr;
    logic [7:0]  mem_data;
    logic [7:0]  draw_x;
    logic [7:0]  draw_y;
    logic [3:0]  draw_rows;
    logic [15:0] next_pc;
    logic        last;

    chip8_instruction_executor u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .instruction (instruction),
        .read_data   (read_data),
        .collision   (collision),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .status      (status),
        .mem_addr    (mem_addr),
        .mem_data    (mem_data),
        .draw_x      (draw_x),
        .draw_y      (draw_y),
        .draw_rows   (draw_rows),
        .next_pc     (next_pc),
        .last        (last)
    );

    // Period of 10 ns.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the executor's architectural state.
    logic [7:0]  v_regs [16];
    logic [15:0] i_reg;
    logic [15:0] pc_reg;
    logic [15:0] pc_start;
    int          sp_reg;
    logic [15:0] ret_stack [STACK_DEPTH];
    logic [7:0]  dly_reg;
    int          loads_left;
    logic [3:0]  load_idx;

    result_t pending_words [$];
    int      errors;
    bit      any_error;

    function automatic result_t blank_word(logic [2:0] k, logic [15:0] a, logic [7:0] d);
        result_t r;
        r = '0;
        r.kind = k;
        r.mem_addr = a;
        r.mem_data = d;
        return r;
    endfunction

    // Executes one input word on the shadow state and queues the result
    // words it must produce, in order.
    task automatic predict_word(input logic [1:0] rtype, input logic [15:0] w,
                                input logic [7:0] rd, input logic cl);
        result_t     res [$];
        logic [2:0]  st;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  n;
        logic [7:0]  kk;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [8:0]  sum;
        result_t     r;
        st = c8x_pkg::ST_OK;
        x = w[11:8];
        y = w[7:4];
        n = w[3:0];
        kk = w[7:0];
        a = v_regs[x];
        b = v_regs[y];
        res.push_back(blank_word(c8x_pkg::KIND_DONE, 16'h0, 8'h0));
        if (rtype == c8x_pkg::REQ_BYTE)
        begin
            if (loads_left != 0)
            begin
                v_regs[load_idx] = rd;
                load_idx = load_idx + 4'd1;
                loads_left--;
            end
        end
        else if (rtype == c8x_pkg::REQ_COLL)
        begin
            v_regs[15] = {7'd0, cl};
        end
        else if (rtype == c8x_pkg::REQ_INSTR)
        begin
            pc_reg = pc_reg + 16'd2;
            case (w[15:12])
                4'h0:
                begin
                    if (w == 16'h00E0) res[0].kind = c8x_pkg::KIND_CLS;
                    else if (w == 16'h00EE)
                    begin
                        if (sp_reg == 0) st = c8x_pkg::ST_UNDERFLOW;
                        else
                        begin
                            sp_reg--;
                            pc_reg = ret_stack[sp_reg];
                        end
                    end
                    else pc_reg = {4'h0, w[11:0]};
                end
                4'h1: pc_reg = {4'h0, w[11:0]};
                4'h2:
                begin
                    if (sp_reg >= STACK_DEPTH) st = c8x_pkg::ST_OVERFLOW;
                    else
                    begin
                        ret_stack[sp_reg] = pc_reg;
                        sp_reg++;
                        pc_reg = {4'h0, w[11:0]};
                    end
                end
                4'h3: if (a == kk) pc_reg = pc_reg + 16'd2;
                4'h4: if (a != kk) pc_reg = pc_reg + 16'd2;
                4'h5: if (a == b) pc_reg = pc_reg + 16'd2;
                4'h6: v_regs[x] = kk;
                4'h7: v_regs[x] = a + kk;
                4'h8:
                begin
                    // The flag is written last so that it wins when x is F.
                    case (n)
                        4'h0: v_regs[x] = b;
                        4'h1: v_regs[x] = a | b;
                        4'h2: v_regs[x] = a & b;
                        4'h3: v_regs[x] = a ^ b;
                        4'h4:
                        begin
                            sum = {1'b0, a} + {1'b0, b};
                            v_regs[x] = sum[7:0];
                            v_regs[15] = {7'd0, sum[8]};
                        end
                        4'h5:
                        begin
                            v_regs[x] = a - b;
                            v_regs[15] = {7'd0, a >= b};
                        end
                        4'h6:
                        begin
                            v_regs[x] = a >> 1;
                            v_regs[15] = {7'd0, a[0]};
                        end
                        4'h7:
                        begin
                            v_regs[x] = b - a;
                            v_regs[15] = {7'd0, b >= a};
                        end
                        4'hE:
                        begin
                            v_regs[x] = a << 1;
                            v_regs[15] = {7'd0, a[7]};
                        end
                        default: st = c8x_pkg::ST_UNKNOWN;
                    endcase
                end
                4'h9: if (a != b) pc_reg = pc_reg + 16'd2;
                4'hA: i_reg = {4'h0, w[11:0]};
                4'hB, 4'hC: st = c8x_pkg::ST_UNIMPL;
                4'hD:
                begin
                    res[0] = blank_word(c8x_pkg::KIND_DRAW, i_reg, 8'h0);
                    res[0].draw_x = a;
                    res[0].draw_y = b;
                    res[0].draw_rows = n;
                end
                4'hE: st = (kk == 8'h9E || kk == 8'hA1) ? c8x_pkg::ST_UNIMPL
                                                        : c8x_pkg::ST_UNKNOWN;
                default:
                begin
                    case (kk)
                        8'h07: v_regs[x] = dly_reg;
                        8'h15: dly_reg = a;
                        8'h1E: i_reg = i_reg + {8'h0, a};
                        8'h0A, 8'h29, 8'h18: st = c8x_pkg::ST_UNIMPL;
                        8'h33:
                        begin
                            res.delete();
                            res.push_back(blank_word(c8x_pkg::KIND_WRITE, i_reg,
                                                     8'(a / 8'd100)));
                            res.push_back(blank_word(c8x_pkg::KIND_WRITE, i_reg + 16'd1,
                                                     8'((a / 8'd10) % 8'd10)));
                            res.push_back(blank_word(c8x_pkg::KIND_WRITE, i_reg + 16'd2,
                                                     8'(a % 8'd10)));
                        end
                        8'h55:
                        begin
                            res.delete();
                            for (int k = 0; k <= x; k++)
                                res.push_back(blank_word(c8x_pkg::KIND_WRITE,
                                                         i_reg + 16'(k), v_regs[k]));
                        end
                        8'h65:
                        begin
                            res.delete();
                            for (int k = 0; k <= x; k++)
                                res.push_back(blank_word(c8x_pkg::KIND_READ,
                                                         i_reg + 16'(k), 8'h0));
                            loads_left = x + 1;
                            load_idx = 4'd0;
                        end
                        default: st = c8x_pkg::ST_UNKNOWN;
                    endcase
                end
            endcase
        end
        foreach (res[k])
        begin
            r = res[k];
            r.status = st;
            r.next_pc = pc_reg;
            r.last = (k == res.size() - 1);
            pending_words.push_back(r);
        end
    endtask

    task automatic reset_shadow();
        foreach (v_regs[k]) v_regs[k] = 8'h0;
        foreach (ret_stack[k]) ret_stack[k] = 16'h0;
        i_reg = 16'h0;
        pc_start = c8x_pkg::START_PC_RESET;
        pc_reg = pc_start;
        sp_reg = 0;
        dly_reg = 8'h0;
        loads_left = 0;
        load_idx = 4'd0;
    endtask

    // Gap length: none half of the time, otherwise mostly short, sometimes long.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Drives one input word and waits for acceptance, then predicts it.
    // With no gap, valid stays high and the next word follows at once.
    task automatic send_word(input logic [1:0] rtype, input logic [15:0] w,
                             input logic [7:0] rd, input logic cl);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rtype;
        instruction <= w;
        read_data <= rd;
        collision <= cl;
        // The ready seen at the edge itself decides acceptance.
        @(posedge clk iff in_ready);
        predict_word(rtype, w, rd, cl);
    endtask

    // Drops valid and waits until every expected word has come out.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_start_pc(input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        pc_start = val;
        pc_reg = val;
    endtask

    // Receiver side: random back-pressure on the output channel.
    initial
    begin
        int g;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            g = gap_len();
            out_ready <= 1'b0;
            repeat (g) @(posedge clk);
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Output checker: compares each taken word with the oldest expectation.
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected result word kind=%0d", kind);
                errors++;
            end
            else
            begin
                e = pending_words.pop_front();
                if (kind !== e.kind)
                begin
                    $error("kind exp %0d got %0d", e.kind, kind); errors++;
                end
                if (status !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, status); errors++;
                end
                if (mem_addr !== e.mem_addr)
                begin
                    $error("mem_addr exp %h got %h", e.mem_addr, mem_addr); errors++;
                end
                if (mem_data !== e.mem_data)
                begin
                    $error("mem_data exp %h got %h", e.mem_data, mem_data); errors++;
                end
                if (draw_x !== e.draw_x)
                begin
                    $error("draw_x exp %h got %h", e.draw_x, draw_x); errors++;
                end
                if (draw_y !== e.draw_y)
                begin
                    $error("draw_y exp %h got %h", e.draw_y, draw_y); errors++;
                end
                if (draw_rows !== e.draw_rows)
                begin
                    $error("draw_rows exp %h got %h", e.draw_rows, draw_rows); errors++;
                end
                if (next_pc !== e.next_pc)
                begin
                    $error("next_pc exp %h got %h", e.next_pc, next_pc); errors++;
                end
                if (last !== e.last)
                begin
                    $error("last exp %0d got %0d", e.last, last); errors++;
                end
            end
        end
    end

    // Random instruction: mostly valid opcodes with random operands, with
    // extra weight on the block transfers and the call/return pair.
    function automatic logic [15:0] rand_instr();
        logic [15:0] w;
        int p;
        w = 16'($urandom);
        p = $urandom_range(0, 99);
        if (p < 8)       w = {4'h2, w[11:0]};
        else if (p < 16) w = 16'h00EE;
        else if (p < 22) w = {4'hF, 4'($urandom_range(0, 3)), 8'h65};
        else if (p < 28) w = {4'hF, w[11:8], 8'h55};
        else if (p < 32) w = {4'hF, w[11:8], 8'h33};
        else if (p < 48) w = {4'h8, w[11:4], 4'($urandom_range(0, 7))};
        else if (p < 52) w = {4'h8, w[11:4], 4'hE};
        else if (p < 62) w = {4'h6, w[11:0]};
        else if (p < 66) w = {4'hF, w[11:8], 8'h1E};
        else if (p < 70) w = 16'h00E0;
        return w;
    endfunction

    initial
    begin
        row_t dir_rows [$];
        row_t rw;
        logic [15:0] cfg_vals [4];
        int p;

        errors = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 16'h0;
        in_valid = 1'b0;
        req_type = c8x_pkg::REQ_INSTR;
        instruction = 16'h0;
        read_data = 8'h0;
        collision = 1'b0;
        reset_shadow();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: {type, word, byte, flag, typed?, kind, status, pc}.
        // The program counter after reset starts from 0x200.
        dir_rows = '{
            '{c8x_pkg::REQ_INSTR, 16'h00EE, 8'h00, 1'b0, 1'b1, c8x_pkg::KIND_DONE,
              c8x_pkg::ST_UNDERFLOW, 16'h0202},
            '{c8x_pkg::REQ_INSTR, 16'h00E0, 8'h00, 1'b0, 1'b1, c8x_pkg::KIND_CLS,
              c8x_pkg::ST_OK, 16'h0204},
            '{c8x_pkg::REQ_INSTR, 16'h6FFF, 8'h00, 1'b0, 1'b1, c8x_pkg::KIND_DONE,
              c8x_pkg::ST_OK, 16'h0206},
            '{c8x_pkg::REQ_INSTR, 16'h60FF, 8'h00, 1'b0, 1'b0, c8x_pkg::KIND_DONE,
              c8x_pkg::ST_OK, 16'h0},
            '{c8x_pkg::REQ_INSTR, 16'h8F04, 8'h00, 1'b0, 1'b0, c8x_pkg::KIND_DONE,
              c8x_pkg::ST_OK, 16'h0},
            '{c8x_pkg::REQ_INSTR, 16'h8F0E, 8'h00, 1'b0, 1'b0, c8x_pkg::KIND_DONE,
              c8x_pkg::ST_OK, 16'h0},
            '{c8x_pkg::REQ_INSTR, 16'h8018, 8'h00, 1'b0, 1'b1, c8x_pkg::KIND_DONE,
              c8x_pkg::ST_UNKNOWN, 16'h020E},
            '{c8x_pkg::REQ_INSTR, 16'hB123, 8'h00, 1'b0, 1'b1, c8x_pkg::KIND_DONE,
              c8x_pkg::ST_UNIMPL, 16'h0210},
            '{c8x_pkg::REQ_INSTR, 16'hC0FF, 8'h00, 1'b0, 1'b1, c8x_pkg::KIND_DONE,
              c8x_pkg::ST_UNIMPL, 16'h0212},
            '{c8x_pkg::REQ_INSTR, 16'hE09E, 8'h00, 1'b0, 1'b1, c8x_pkg::KIND_DONE,
              c8x_pkg::ST_UNIMPL, 16'h0214},
            '{c8x_pkg::REQ_INSTR, 16'hE000, 8'h00, 1'b0, 1'b1, c8x_pkg::KIND_DONE,
              c8x_pkg::ST_UNKNOWN, 16'h0216},
            '{c8x_pkg::REQ_INSTR, 16'hF0FF, 8'h00, 1'b0, 1'b1, c8x_pkg::KIND_DONE,
              c8x_pkg::ST_UNKNOWN, 16'h0218},
            '{c8x_pkg::REQ_BYTE, 16'h0000, 8'hAA, 1'b0, 1'b0, c8x_pkg::KIND_DONE,
              c8x_pkg::ST_OK, 16'h0},
            '{c8x_pkg::REQ_COLL, 16'h0000, 8'h00, 1'b1, 1'b0, c8x_pkg::KIND_DONE,
              c8x_pkg::ST_OK, 16'h0},
            '{REQ_SPARE, 16'hFFFF, 8'hFF, 1'b1, 1'b0, c8x_pkg::KIND_DONE,
              c8x_pkg::ST_OK, 16'h0},
            '{c8x_pkg::REQ_INSTR, 16'hAFFE, 8'h00, 1'b0, 1'b0, c8x_pkg::KIND_DONE,
              c8x_pkg::ST_OK, 16'h0},
            '{c8x_pkg::REQ_INSTR, 16'hF033, 8'h00, 1'b0, 1'b0, c8x_pkg::KIND_DONE,
              c8x_pkg::ST_OK, 16'h0},
            '{c8x_pkg::REQ_INSTR, 16'hFF55, 8'h00, 1'b0, 1'b0, c8x_pkg::KIND_DONE,
              c8x_pkg::ST_OK, 16'h0},
            '{c8x_pkg::REQ_INSTR, 16'hF265, 8'h00, 1'b0, 1'b0, c8x_pkg::KIND_DONE,
              c8x_pkg::ST_OK, 16'h0},
            '{c8x_pkg::REQ_BYTE, 16'h0000, 8'h55, 1'b0, 1'b0, c8x_pkg::KIND_DONE,
              c8x_pkg::ST_OK, 16'h0},
            '{c8x_pkg::REQ_INSTR, 16'h5019, 8'h00, 1'b0, 1'b0, c8x_pkg::KIND_DONE,
              c8x_pkg::ST_OK, 16'h0},
            '{c8x_pkg::REQ_INSTR, 16'hDF00, 8'h00, 1'b0, 1'b0, c8x_pkg::KIND_DONE,
              c8x_pkg::ST_OK, 16'h0},
            '{c8x_pkg::REQ_INSTR, 16'h2FFF, 8'h00, 1'b0, 1'b0, c8x_pkg::KIND_DONE,
              c8x_pkg::ST_OK, 16'h0},
            '{c8x_pkg::REQ_INSTR, 16'h0123, 8'h00, 1'b0, 1'b0, c8x_pkg::KIND_DONE,
              c8x_pkg::ST_OK, 16'h0}
        };
        foreach (dir_rows[k])
        begin
            rw = dir_rows[k];
            send_word(rw.rtype, rw.word, rw.byte_in, rw.coll);
            if (rw.has_exp)
            begin
                // Cross-check the typed value against the prediction.
                if (pending_words[$].kind !== rw.exp_kind
                    || pending_words[$].status !== rw.exp_status
                    || pending_words[$].next_pc !== rw.exp_pc)
                begin
                    $error("row %0d typed result disagrees with prediction", k);
                    errors++;
                end
            end
        end
        // Fill the return stack up to the overflow case, then empty it.
        repeat (STACK_DEPTH + 1) send_word(c8x_pkg::REQ_INSTR, 16'h2ABC, 8'h0, 1'b0);
        repeat (STACK_DEPTH) send_word(c8x_pkg::REQ_INSTR, 16'h00EE, 8'h0, 1'b0);
        drain();

        // Random phases, each under a different start address.
        cfg_vals = '{16'hFFFE, 16'h0000, 16'($urandom), 16'h0200};
        foreach (cfg_vals[c])
        begin
            write_start_pc(cfg_vals[c]);
            for (int k = 0; k < 95; k++)
            begin
                p = $urandom_range(0, 99);
                if (p < 80)
                    send_word(c8x_pkg::REQ_INSTR, rand_instr(), 8'h0, 1'b0);
                else if (p < 92)
                    send_word(c8x_pkg::REQ_BYTE, 16'($urandom), 8'($urandom),
                              1'($urandom));
                else
                    send_word(2'($urandom_range(2, 3)), 16'($urandom), 8'($urandom),
                              1'($urandom));
            end
            drain();
        end

        any_error = (errors != 0) || (pending_words.size() != 0);
        if (!any_error)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
